>>> rtl/plf_pkg.sv
// Shared constants, command codes and memory access structures for the Playfair engine.
package plf_pkg;

  localparam int unsigned NCell = 25;
  localparam int unsigned Side  = 5;

  localparam logic [4:0] FILLER    = 5'd23;
  localparam logic [4:0] LAST_CELL = 5'(NCell - 1);
  localparam logic [4:0] FULL      = 5'(NCell);
  localparam logic [6:0] CHAR_BASE = 7'd65;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_KEY    = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_TEXT   = 2'd3
  } cmd_t;

  // Write side of both tables: the square (cell to letter) and the
  // position table (letter to cell) are always written together.
  typedef struct packed {
    logic       we;
    logic [4:0] slot;
    logic [4:0] letter;
  } mem_wr_t;

  // Read side: two position reads, then two square reads.
  typedef struct packed {
    logic       pos_re;
    logic [4:0] pos_addr_a;
    logic [4:0] pos_addr_b;
    logic       sq_re;
    logic [4:0] sq_addr_a;
    logic [4:0] sq_addr_b;
  } mem_rd_t;

endpackage

>>> rtl/plf_store.sv
// Square and letter position memories, one write port and two registered read ports each.
module plf_store (
  input  logic             clk,
  input  plf_pkg::mem_wr_t wr,
  input  plf_pkg::mem_rd_t rd,
  output logic [4:0]       pos_a,
  output logic [4:0]       pos_b,
  output logic [4:0]       sq_a,
  output logic [4:0]       sq_b
);

  logic [4:0] sq_mem  [plf_pkg::NCell];
  logic [4:0] pos_mem [plf_pkg::NCell];
  logic [4:0] pos_a_r, pos_b_r, sq_a_r, sq_b_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      sq_mem[wr.slot]    <= wr.letter;
      pos_mem[wr.letter] <= wr.slot;
    end
    if (rd.pos_re) begin
      pos_a_r <= pos_mem[rd.pos_addr_a];
      pos_b_r <= pos_mem[rd.pos_addr_b];
    end
    if (rd.sq_re) begin
      sq_a_r <= sq_mem[rd.sq_addr_a];
      sq_b_r <= sq_mem[rd.sq_addr_b];
    end
  end

  assign pos_a = pos_a_r;
  assign pos_b = pos_b_r;
  assign sq_a  = sq_a_r;
  assign sq_b  = sq_b_r;

endmodule

>>> rtl/plf_geom.sv
// Pair geometry: turns two cell positions into the two square cells of the cipher pair.
module plf_geom (
  input  logic       decrypt,
  input  logic [4:0] pos_a,
  input  logic [4:0] pos_b,
  output logic [4:0] cell_a,
  output logic [4:0] cell_b
);

  function automatic logic [2:0] row_of(input logic [4:0] p);
    logic [2:0] r;
    if (p >= 5'd20)      r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5)  r = 3'd1;
    else                 r = 3'd0;
    return r;
  endfunction

  function automatic logic [2:0] col_of(input logic [4:0] p, input logic [2:0] r);
    logic [4:0] c;
    c = p - ({r, 2'b00} + {2'b00, r});
    return c[2:0];
  endfunction

  // Step one place along a row or column, wrapping at the edge.
  function automatic logic [2:0] step(input logic [2:0] x, input logic dec);
    logic [2:0] y;
    if (dec) y = (x == 3'd0) ? 3'(plf_pkg::Side - 1) : x - 3'd1;
    else     y = (x == 3'(plf_pkg::Side - 1)) ? 3'd0 : x + 3'd1;
    return y;
  endfunction

  function automatic logic [4:0] cell_of(input logic [2:0] r, input logic [2:0] c);
    return {r, 2'b00} + {2'b00, r} + {2'b00, c};
  endfunction

  logic [2:0] ra, ca, rb, cb;

  always_comb begin
    ra = row_of(pos_a);
    rb = row_of(pos_b);
    ca = col_of(pos_a, ra);
    cb = col_of(pos_b, rb);
    // A pair of equal letters lands on the same row and takes the row rule.
    if (ra == rb) begin
      cell_a = cell_of(ra, step(ca, decrypt));
      cell_b = cell_of(rb, step(cb, decrypt));
    end else if (ca == cb) begin
      cell_a = cell_of(step(ra, decrypt), ca);
      cell_b = cell_of(step(rb, decrypt), cb);
    end else begin
      cell_a = cell_of(rb, ca);
      cell_b = cell_of(ra, cb);
    end
  end

endmodule

>>> rtl/playfair_cipher_engine.sv
// Playfair cipher engine top level: command sequencer, key fill and result output register.
// Clear, key letter and unpaired text commands are handled in S_IDLE; finish sweeps 25 letters.
// A pair's first result is loaded in S_OUT_A after the S_POS and S_SQ reads, its second in
// S_OUT_B, and a flushed second pair runs S_POS to S_OUT_B again; an error result in S_ERR.
// The input is held off until a pair and any flush are done, including any output stall.
// Reset is synchronous and active low; it clears the flags and counters, not the memories.
module playfair_cipher_engine (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_letter,
  input  logic       in_text_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_char,
  output logic       out_run_last,
  output logic       out_bad_input
);

  // The sequencer accepts one command at a time from the idle state. Text pairs are
  // resolved in two memory steps: first both letters' cells are read from the position
  // table, then the geometry unit forms the two result cells and the square is read.
  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_ERR,
    S_POS,
    S_SQ,
    S_OUT_A,
    S_OUT_B
  } state_t;

  state_t      state_r;
  logic        decrypt_r;
  logic [24:0] present_r;
  logic [4:0]  fill_count_r;
  logic [4:0]  fill_idx_r;
  logic        key_ready_r;
  logic [4:0]  pend_r;
  logic        pend_valid_r;
  logic [4:0]  pair_a_r;
  logic [4:0]  pair_b_r;
  logic [4:0]  letter_r;
  logic        second_r;
  logic        out_valid_r;
  logic [6:0]  out_char_r;
  logic        out_run_last_r;
  logic        out_bad_r;

  plf_pkg::cmd_t    cmd;
  plf_pkg::mem_wr_t wr;
  plf_pkg::mem_rd_t rd;

  logic       lt_ok;
  logic [4:0] lt_idx;
  logic [7:0] lt_off;
  logic       key_place;
  logic       fill_place;
  logic       out_free;
  logic       out_load;
  logic [4:0] pos_a, pos_b, sq_a, sq_b, cell_a, cell_b;

  assign cmd      = plf_pkg::cmd_t'(in_cmd);
  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign out_load = out_free && (state_r inside {S_ERR, S_OUT_A, S_OUT_B});

  // Letter decode: case is ignored and Z folds onto X.
  always_comb begin
    lt_ok  = 1'b0;
    lt_off = 8'd0;
    if (in_letter >= 8'd65 && in_letter <= 8'd90) begin
      lt_ok  = 1'b1;
      lt_off = in_letter - 8'd65;
    end else if (in_letter >= 8'd97 && in_letter <= 8'd122) begin
      lt_ok  = 1'b1;
      lt_off = in_letter - 8'd97;
    end
    lt_idx = (lt_off[4:0] == 5'(plf_pkg::NCell)) ? plf_pkg::FILLER : lt_off[4:0];
  end

  // A key letter takes the next free cell unless it is already placed or the square is full.
  // The finish sweep places every letter that is still missing in alphabetical order.
  assign key_place  = in_valid && in_ready && (cmd == plf_pkg::CMD_KEY) && lt_ok &&
                      !present_r[lt_idx] && (fill_count_r < plf_pkg::FULL);
  assign fill_place = (state_r == S_FILL) && !present_r[fill_idx_r] &&
                      (fill_count_r < plf_pkg::FULL);

  always_comb begin
    wr.we     = key_place || fill_place;
    wr.slot   = fill_count_r;
    wr.letter = (state_r == S_FILL) ? fill_idx_r : lt_idx;
    rd.pos_re     = (state_r == S_POS);
    rd.pos_addr_a = pair_a_r;
    rd.pos_addr_b = pair_b_r;
    rd.sq_re      = (state_r == S_SQ);
    rd.sq_addr_a  = cell_a;
    rd.sq_addr_b  = cell_b;
  end

  plf_store u_store (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .pos_a (pos_a),
    .pos_b (pos_b),
    .sq_a  (sq_a),
    .sq_b  (sq_b)
  );

  plf_geom u_geom (
    .decrypt (decrypt_r),
    .pos_a   (pos_a),
    .pos_b   (pos_b),
    .cell_a  (cell_a),
    .cell_b  (cell_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decrypt_r <= 1'b0;
    end else if (cfg_wr_en) begin
      decrypt_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      present_r    <= '0;
      fill_count_r <= '0;
      fill_idx_r   <= '0;
      key_ready_r  <= 1'b0;
      pend_r       <= '0;
      pend_valid_r <= 1'b0;
      second_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // The output register empties on a transfer unless a new result is loaded below.
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            case (cmd)
              plf_pkg::CMD_CLEAR: begin
                present_r    <= '0;
                fill_count_r <= '0;
                key_ready_r  <= 1'b0;
                pend_valid_r <= 1'b0;
              end
              plf_pkg::CMD_KEY: begin
                if (key_place) begin
                  present_r[lt_idx] <= 1'b1;
                  fill_count_r      <= fill_count_r + 5'd1;
                end
              end
              plf_pkg::CMD_FINISH: begin
                fill_idx_r <= '0;
                state_r    <= S_FILL;
              end
              plf_pkg::CMD_TEXT: begin
                letter_r <= lt_idx;
                if (!key_ready_r || !lt_ok) begin
                  pend_valid_r <= 1'b0;
                  state_r      <= S_ERR;
                end else if (pend_valid_r && (pend_r == lt_idx)) begin
                  // Doubled letter: X goes between; the new copy stays pending, or is flushed at text end.
                  pair_a_r <= pend_r;
                  pair_b_r <= plf_pkg::FILLER;
                  second_r <= in_text_end;
                  if (in_text_end) begin
                    pend_valid_r <= 1'b0;
                  end
                  state_r <= S_POS;
                end else if (pend_valid_r) begin
                  pair_a_r     <= pend_r;
                  pair_b_r     <= lt_idx;
                  second_r     <= 1'b0;
                  pend_valid_r <= 1'b0;
                  state_r      <= S_POS;
                end else if (in_text_end) begin
                  // A lone tail letter is padded with X.
                  pair_a_r <= lt_idx;
                  pair_b_r <= plf_pkg::FILLER;
                  second_r <= 1'b0;
                  state_r  <= S_POS;
                end else begin
                  pend_r       <= lt_idx;
                  pend_valid_r <= 1'b1;
                end
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_FILL: begin
          if (fill_place) begin
            present_r[fill_idx_r] <= 1'b1;
            fill_count_r          <= fill_count_r + 5'd1;
          end
          if (fill_idx_r == plf_pkg::LAST_CELL) begin
            key_ready_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            fill_idx_r <= fill_idx_r + 5'd1;
          end
        end
        S_ERR: begin
          if (out_free) begin
            out_valid_r    <= 1'b1;
            out_char_r     <= '0;
            out_run_last_r <= 1'b1;
            out_bad_r      <= 1'b1;
            state_r        <= S_IDLE;
          end
        end
        S_POS: begin
          state_r <= S_SQ;
        end
        S_SQ: begin
          state_r <= S_OUT_A;
        end
        S_OUT_A: begin
          if (out_free) begin
            out_valid_r    <= 1'b1;
            out_char_r     <= plf_pkg::CHAR_BASE + {2'b00, sq_a};
            out_run_last_r <= 1'b0;
            out_bad_r      <= 1'b0;
            state_r        <= S_OUT_B;
          end
        end
        S_OUT_B: begin
          if (out_free) begin
            out_valid_r    <= 1'b1;
            out_char_r     <= plf_pkg::CHAR_BASE + {2'b00, sq_b};
            out_run_last_r <= !second_r;
            out_bad_r      <= 1'b0;
            if (second_r) begin
              // End of message with a doubled letter: flush it padded with X.
              pair_a_r <= letter_r;
              pair_b_r <= plf_pkg::FILLER;
              second_r <= 1'b0;
              state_r  <= S_POS;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char      = out_char_r;
  assign out_run_last  = out_run_last_r;
  assign out_bad_input = out_bad_r;

  // The fill count always matches the number of placed letters.
  a_fill_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(present_r) == 32'(fill_count_r))
    else $error("fill count differs from placed letters");

  // A finished key means every cell of the square holds a letter.
  a_key_full: assert property (@(posedge clk) disable iff (!rst_n)
    key_ready_r |-> (fill_count_r == plf_pkg::FULL))
    else $error("key ready with square not full");

  // Memory lookups and pending letters exist only under a finished key.
  a_pend_key: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_valid_r || state_r == S_POS || state_r == S_SQ) |-> key_ready_r)
    else $error("text work without a finished key");

  // An error result is always the only and last result of its item.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_r) |-> out_run_last_r)
    else $error("error result not marked last");

endmodule
